// ===== design/tacho_motor_position_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tacho motor position controller
// Shared helpers for the concurrent checks on the controller ports.
// ----------------------------------------------------------------------------
`ifndef TACHO_MOTOR_POSITION_CONTROLLER_MACROS_SVH
`define TACHO_MOTOR_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define TMPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmpc check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define TMPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmpc check failed");

`endif

// ===== design/tmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tacho motor position controller package
// Request and result types, motor state, action and mode codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmpc_pkg;

  typedef enum logic [2:0] {
    ACT_EDGE   = 3'd0,
    ACT_STOP   = 3'd1,
    ACT_ROTATE = 3'd2,
    ACT_ANGLE  = 3'd3,
    ACT_TIME   = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_CONT  = 2'd1,
    MODE_ANGLE = 2'd2,
    MODE_TIME  = 2'd3
  } mode_t;

  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;

  typedef struct packed {
    action_t            action;
    logic [2:0]         motor;
    logic               tach_level;
    logic               dir_level;
    logic signed [7:0]  speed;
    logic [31:0]        amount;
    logic               brake_req;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic               drive_valid;
    logic [1:0]         drive_motor;
    logic signed [7:0]  drive_speed;
    logic               drive_brake;
    logic [31:0]        tach_count;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    logic        brake;
    logic [31:0] count;
    logic [31:0] target;
  } motor_state_t;

endpackage

// ===== design/tmpc_step.sv =====
// ----------------------------------------------------------------------------
// Tacho motor step logic
// Computes the updated state of the addressed motor and the result of one
// request: tach counting, auto-stop checks and command decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmpc_step (
  input  logic                   motor_ok,
  input  tmpc_pkg::item_t        item,
  input  tmpc_pkg::motor_state_t cur,
  output tmpc_pkg::motor_state_t upd,
  output tmpc_pkg::result_t      res
);

  logic signed [7:0] spd;
  logic [31:0]       cnt_next;
  logic              hit;

  always_comb begin
    if (item.speed > tmpc_pkg::SPEED_MAX) begin
      spd = tmpc_pkg::SPEED_MAX;
    end else if (item.speed < tmpc_pkg::SPEED_MIN) begin
      spd = tmpc_pkg::SPEED_MIN;
    end else begin
      spd = item.speed;
    end
  end

  // Counts up when the tach and direction levels differ, down otherwise.
  assign cnt_next = (item.tach_level != item.dir_level) ? cur.count + 32'd1
                                                         : cur.count - 32'd1;

  // The time target is only looked at when an edge arrives.
  assign hit = ((cur.mode == tmpc_pkg::MODE_ANGLE) && (cnt_next == cur.target)) ||
               ((cur.mode == tmpc_pkg::MODE_TIME) && (item.now_ms >= cur.target));

  always_comb begin
    upd = cur;
    res = '0;
    if (motor_ok) begin
      unique case (item.action)
        tmpc_pkg::ACT_EDGE: begin
          upd.count = cnt_next;
          if (hit) begin
            upd.mode        = tmpc_pkg::MODE_STOP;
            res.drive_valid = 1'b1;
            res.drive_brake = cur.brake;
          end
        end
        tmpc_pkg::ACT_STOP: begin
          upd.mode        = tmpc_pkg::MODE_STOP;
          res.drive_valid = 1'b1;
          res.drive_brake = item.brake_req;
        end
        tmpc_pkg::ACT_ROTATE: begin
          upd.mode        = tmpc_pkg::MODE_CONT;
          res.drive_valid = 1'b1;
          res.drive_speed = spd;
        end
        tmpc_pkg::ACT_ANGLE, tmpc_pkg::ACT_TIME: begin
          res.drive_valid = 1'b1;
          if (spd == 8'sd0) begin
            // A zero speed turns the request into a plain stop.
            upd.mode        = tmpc_pkg::MODE_STOP;
            res.drive_brake = item.brake_req;
          end else begin
            if (item.action == tmpc_pkg::ACT_ANGLE) begin
              upd.target = (spd < 8'sd0) ? cur.count - item.amount
                                         : cur.count + item.amount;
              upd.mode   = tmpc_pkg::MODE_ANGLE;
            end else begin
              upd.target = item.now_ms + item.amount;
              upd.mode   = tmpc_pkg::MODE_TIME;
            end
            upd.brake       = item.brake_req;
            res.drive_speed = spd;
          end
        end
        default: begin
        end
      endcase
      if (res.drive_valid) begin
        res.drive_motor = item.motor[1:0];
      end
      res.tach_count = upd.count;
    end
  end

endmodule

// ===== design/tacho_motor_position_controller.sv =====
// Path: a request goes through the input register, then the result register.
// Throughput: one request per cycle unless the result is stalled; the
// per-motor state register update in the step stage sets this figure. A
// stalled result holds back at most one request in the input register.
// Reset puts every motor in stop mode with brake set and clears counts and
// targets; both channels come out empty.
// ----------------------------------------------------------------------------
// Tacho motor position controller
// Per-motor tach counters with angle and time auto-stop and drive commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacho_motor_position_controller #(
  parameter int NUM_MOTORS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tmpc_pkg::item_t   cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output tmpc_pkg::result_t res
);

  localparam int          IDX_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [3:0]  NUM_ID = 4'(NUM_MOTORS);

  tmpc_pkg::mode_t mode   [NUM_MOTORS];
  logic            brake  [NUM_MOTORS];
  logic [31:0]     count  [NUM_MOTORS];
  logic [31:0]     target [NUM_MOTORS];

  logic                   s1_valid;
  tmpc_pkg::item_t        s1_item;
  logic                   out_free;
  logic                   s1_adv;
  logic                   motor_ok;
  logic [IDX_W-1:0]       idx;
  tmpc_pkg::motor_state_t cur;
  tmpc_pkg::motor_state_t upd;
  tmpc_pkg::result_t      step_res;

  assign out_free  = !res_valid || !res_stall;
  assign s1_adv    = s1_valid && out_free;
  assign cmd_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  assign motor_ok = {1'b0, s1_item.motor} < NUM_ID;
  assign idx      = s1_item.motor[IDX_W-1:0];

  always_comb begin
    if (motor_ok) begin
      cur.mode   = mode[idx];
      cur.brake  = brake[idx];
      cur.count  = count[idx];
      cur.target = target[idx];
    end else begin
      cur = '0;
    end
  end

  tmpc_step u_step (
    .motor_ok (motor_ok),
    .item     (s1_item),
    .cur      (cur),
    .upd      (upd),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        mode[i]   <= tmpc_pkg::MODE_STOP;
        brake[i]  <= 1'b1;
        count[i]  <= 32'd0;
        target[i] <= 32'd0;
      end
    end else if (s1_adv && motor_ok) begin
      mode[idx]   <= upd.mode;
      brake[idx]  <= upd.brake;
      count[idx]  <= upd.count;
      target[idx] <= upd.target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= step_res;
    end
  end

endmodule

// ===== design/tmpc_checker.sv =====
// ----------------------------------------------------------------------------
// Tacho motor position controller port checker
// Concurrent checks on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tacho_motor_position_controller_macros.svh"

module tmpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input tmpc_pkg::item_t   cmd,
  input logic              res_valid,
  input logic              res_stall,
  input tmpc_pkg::result_t res
);

  logic drive_idle;
  logic speed_ok;
  logic running;

  assign drive_idle = (res.drive_motor == 2'd0) && (res.drive_speed == 8'sd0) &&
                      !res.drive_brake;
  assign speed_ok   = (res.drive_speed <= tmpc_pkg::SPEED_MAX) &&
                      (res.drive_speed >= tmpc_pkg::SPEED_MIN);
  assign running    = res.drive_valid && (res.drive_speed != 8'sd0);

  // A stalled request stays on the port unchanged.
  `TMPC_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd))

  // A stalled result stays on the port unchanged.
  `TMPC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // Without a drive command every drive field reads zero.
  `TMPC_ASSERT_NOW(a_no_drive_zero, res_valid && !res.drive_valid, drive_idle)

  // The bridge never sees a speed outside the clamp range.
  `TMPC_ASSERT_NOW(a_speed_range, res_valid && res.drive_valid, speed_ok)

  // Braking only goes with a stop, never with a running speed.
  `TMPC_ASSERT_NOW(a_brake_only_stop, res_valid && running, !res.drive_brake)

endmodule

bind tacho_motor_position_controller tmpc_checker u_tmpc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== bench/tacho_motor_position_checker.sv =====
// ----------------------------------------------------------------------------
// Tacho motor position controller checker
// Watches both channels of the controller. It keeps its own copy of the
// per-motor mode, brake, count and target, predicts the drive command and
// count for every accepted request, and compares each accepted result with
// the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacho_motor_position_checker #(
  parameter int MOTOR_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  tmpc_pkg::item_t   cmd,
  input  logic              res_valid,
  input  logic              res_stall,
  input  tmpc_pkg::result_t res,
  output int                fail_count,
  output int                pending
);

  tmpc_pkg::mode_t motor_mode [MOTOR_COUNT];
  logic            motor_brake[MOTOR_COUNT];
  logic [31:0]     motor_count[MOTOR_COUNT];
  logic [31:0]     motor_target[MOTOR_COUNT];

  tmpc_pkg::result_t drive_q[$];
  tmpc_pkg::result_t want;

  // Applies one request to the motor copy and returns the drive and count.
  function automatic tmpc_pkg::result_t apply_request(input tmpc_pkg::item_t r);
    tmpc_pkg::result_t o;
    logic signed [7:0] spd;
    int unsigned       m;
    o   = '0;
    spd = r.speed;
    if (spd > tmpc_pkg::SPEED_MAX) spd = tmpc_pkg::SPEED_MAX;
    else if (spd < tmpc_pkg::SPEED_MIN) spd = tmpc_pkg::SPEED_MIN;
    if (r.motor < MOTOR_COUNT) begin
      m = 32'(r.motor);
      unique case (r.action)
        tmpc_pkg::ACT_EDGE: begin
          if (r.tach_level != r.dir_level) motor_count[m] = motor_count[m] + 32'd1;
          else motor_count[m] = motor_count[m] - 32'd1;
          if ((motor_mode[m] == tmpc_pkg::MODE_ANGLE && motor_count[m] == motor_target[m]) ||
              (motor_mode[m] == tmpc_pkg::MODE_TIME && r.now_ms >= motor_target[m])) begin
            motor_mode[m] = tmpc_pkg::MODE_STOP;
            o.drive_valid = 1'b1;
            o.drive_brake = motor_brake[m];
          end
        end
        tmpc_pkg::ACT_STOP: begin
          motor_mode[m] = tmpc_pkg::MODE_STOP;
          o.drive_valid = 1'b1;
          o.drive_brake = r.brake_req;
        end
        tmpc_pkg::ACT_ROTATE: begin
          motor_mode[m] = tmpc_pkg::MODE_CONT;
          o.drive_valid = 1'b1;
          o.drive_speed = spd;
        end
        tmpc_pkg::ACT_ANGLE, tmpc_pkg::ACT_TIME: begin
          o.drive_valid = 1'b1;
          if (spd == 0) begin
            // A zero speed turns a run request into a plain stop.
            motor_mode[m] = tmpc_pkg::MODE_STOP;
            o.drive_brake = r.brake_req;
          end else begin
            if (r.action == tmpc_pkg::ACT_ANGLE) begin
              motor_target[m] = (spd < 0) ? motor_count[m] - r.amount
                                          : motor_count[m] + r.amount;
              motor_mode[m] = tmpc_pkg::MODE_ANGLE;
            end else begin
              motor_target[m] = r.now_ms + r.amount;
              motor_mode[m] = tmpc_pkg::MODE_TIME;
            end
            motor_brake[m] = r.brake_req;
            o.drive_speed  = spd;
          end
        end
        default: ;
      endcase
      if (o.drive_valid) o.drive_motor = r.motor[1:0];
      o.tach_count = motor_count[m];
    end
    return o;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    fail_count++;
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_mode[i]   = tmpc_pkg::MODE_STOP;
        motor_brake[i]  = 1'b1;
        motor_count[i]  = '0;
        motor_target[i] = '0;
      end
      drive_q.delete();
      fail_count = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (drive_q.size() == 0) begin
          report_mismatch("unrequested result", res.tach_count, 32'd0);
        end else begin
          want = drive_q.pop_front();
          if (res.drive_valid !== want.drive_valid)
            report_mismatch("drive_valid", 32'(res.drive_valid), 32'(want.drive_valid));
          if (res.drive_motor !== want.drive_motor)
            report_mismatch("drive_motor", 32'(res.drive_motor), 32'(want.drive_motor));
          if (res.drive_speed !== want.drive_speed)
            report_mismatch("drive_speed", 32'(res.drive_speed), 32'(want.drive_speed));
          if (res.drive_brake !== want.drive_brake)
            report_mismatch("drive_brake", 32'(res.drive_brake), 32'(want.drive_brake));
          if (res.tach_count !== want.tach_count)
            report_mismatch("tach_count", res.tach_count, want.tach_count);
        end
      end
      if (cmd_valid && !cmd_stall) drive_q.push_back(apply_request(cmd));
    end
    pending <= drive_q.size();
  end

endmodule

// ===== bench/tacho_motor_position_controller_test.sv =====
// ----------------------------------------------------------------------------
// Tacho motor position controller testbench
// Drives a directed set of edge and command requests, then random requests
// in phases with different sender and receiver idling, and takes the verdict
// from the checker that sits beside the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacho_motor_position_controller_test;

  localparam int          MOTOR_COUNT  = 3;
  localparam int          PHASE_ITEMS  = 285;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 6;
  localparam logic [2:0]  ACT_SPARE_A  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_B  = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  tmpc_pkg::item_t   cmd = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  tmpc_pkg::result_t res;

  int          fail_count;
  int          pending;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  logic        hold_req = 1'b0;
  int          hold_left;
  logic        hold_taken;
  int          quiet_cycles;
  logic [31:0] ms_clock;

  tacho_motor_position_controller #(.NUM_MOTORS(MOTOR_COUNT)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  tacho_motor_position_checker #(.MOTOR_COUNT(MOTOR_COUNT)) drive_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off that fills the block.
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      res_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tmpc_pkg::item_t make_request(input logic [2:0] act,
                                                   input logic [2:0] motor,
                                                   input logic tach, input logic dir,
                                                   input logic [7:0] speed,
                                                   input logic [31:0] amount,
                                                   input logic brake,
                                                   input logic [31:0] now_ms);
    tmpc_pkg::item_t r;
    r.action     = tmpc_pkg::action_t'(act);
    r.motor      = motor;
    r.tach_level = tach;
    r.dir_level  = dir;
    r.speed      = speed;
    r.amount     = amount;
    r.brake_req  = brake;
    r.now_ms     = now_ms;
    return r;
  endfunction

  // Mostly valid motors and small angles and durations, so that random
  // edges actually reach the angle and time stops.
  function automatic tmpc_pkg::item_t random_request();
    logic [2:0]  act;
    logic [2:0]  motor;
    logic [7:0]  speed;
    logic [31:0] amount;
    logic [31:0] now_ms;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 50) act = tmpc_pkg::ACT_EDGE;
    else if (sel < 58) act = tmpc_pkg::ACT_STOP;
    else if (sel < 65) act = tmpc_pkg::ACT_ROTATE;
    else if (sel < 77) act = tmpc_pkg::ACT_ANGLE;
    else if (sel < 89) act = tmpc_pkg::ACT_TIME;
    else if (sel < 96) act = tmpc_pkg::ACT_READ;
    else act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    motor = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
    if ($urandom_range(2) == 0) speed = 8'(int'($urandom_range(20)) - 10);
    else speed = 8'($urandom);
    if ($urandom_range(4) == 0) amount = $urandom;
    else if (act == tmpc_pkg::ACT_TIME) amount = $urandom_range(20);
    else amount = $urandom_range(6);
    ms_clock = ms_clock + $urandom_range(3);
    now_ms = ($urandom_range(19) == 0) ? $urandom : ms_clock;
    return make_request(act, motor, 1'($urandom_range(1)), 1'($urandom_range(1)), speed,
                        amount, 1'($urandom_range(1)), now_ms);
  endfunction

  task automatic send_request(input tmpc_pkg::item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= r;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    ms_clock           = 32'd5000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Counting, wrap below zero and speed clamping.
    send_request(make_request(tmpc_pkg::ACT_READ, 3'd0, 1'b0, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd0, 1'b1, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd0, 1'b1, 1'b1, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd0, 1'b0, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_ROTATE, 3'd1, 1'b0, 1'b0, 8'sd127, 32'd0, 1'b0,
                              32'd0));
    // The most negative speed clamps to the lower limit.
    send_request(make_request(tmpc_pkg::ACT_ROTATE, 3'd1, 1'b0, 1'b0, 8'h80, 32'd0, 1'b0,
                              32'd0));
    send_request(make_request(tmpc_pkg::ACT_ROTATE, 3'd2, 1'b0, 1'b0, 8'sd0, 32'd0, 1'b0,
                              32'd0));
    // Angle run forward to a stop that uses the stored coast setting.
    send_request(make_request(tmpc_pkg::ACT_ANGLE, 3'd0, 1'b0, 1'b0, 8'sd50, 32'd2, 1'b0,
                              32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd0, 1'b0, 1'b1, 8'sd0, 32'd0, 1'b1, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd0, 1'b1, 1'b0, 8'sd0, 32'd0, 1'b1, 32'd0));
    // Angle run backward through zero.
    send_request(make_request(tmpc_pkg::ACT_ANGLE, 3'd1, 1'b0, 1'b0, -8'sd100, 32'd1, 1'b1,
                              32'd0));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd1, 1'b0, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_ANGLE, 3'd1, 1'b0, 1'b0, 8'sd0, 32'd9, 1'b1,
                              32'd0));
    // Time run whose target wraps: the unsigned compare stops it at once.
    send_request(make_request(tmpc_pkg::ACT_TIME, 3'd2, 1'b0, 1'b0, 8'sd30, 32'd10, 1'b0,
                              32'hFFFF_FFFA));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd2, 1'b1, 1'b0, 8'sd0, 32'd0, 1'b1,
                              32'hFFFF_FFFF));
    send_request(make_request(tmpc_pkg::ACT_TIME, 3'd2, 1'b0, 1'b0, -8'sd5, 32'd100, 1'b1,
                              32'd1000));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd2, 1'b0, 1'b1, 8'sd0, 32'd0, 1'b0,
                              32'd1050));
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd2, 1'b0, 1'b1, 8'sd0, 32'd0, 1'b0,
                              32'd1100));
    send_request(make_request(tmpc_pkg::ACT_TIME, 3'd0, 1'b0, 1'b0, 8'sd0, 32'd7, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_STOP, 3'd0, 1'b0, 1'b0, 8'sd90, 32'd0, 1'b1,
                              32'd0));
    send_request(make_request(tmpc_pkg::ACT_STOP, 3'd1, 1'b0, 1'b0, -8'sd90, 32'd0, 1'b0,
                              32'd0));
    // Invalid motors and the unused action codes change nothing.
    send_request(make_request(tmpc_pkg::ACT_EDGE, 3'd3, 1'b1, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(tmpc_pkg::ACT_ROTATE, 3'd7, 1'b0, 1'b0, 8'sd20, 32'd0, 1'b0,
                              32'd0));
    send_request(make_request(tmpc_pkg::ACT_READ, 3'd4, 1'b0, 1'b0, 8'sd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(ACT_SPARE_A, 3'd1, 1'b1, 1'b0, 8'sd40, 32'd3, 1'b1, 32'd0));
    send_request(make_request(ACT_SPARE_B, 3'd0, 1'b0, 1'b1, 8'sd40, 32'd3, 1'b0, 32'd0));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_req <= 1'b1;
        end
        1: begin
          sender_idle_pct    = 70;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 70;
        end
        default: begin
          sender_idle_pct    = 31;
          receiver_stall_pct = 31;
        end
      endcase
      repeat (PHASE_ITEMS) send_request(random_request());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
